/* rtl/stsi_pkg.sv */
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types and constants of the sorted table search/insert block.
// ----------------------------------------------------------------------------
package stsi_pkg;

	localparam int unsigned DEPTH_DEF  = 1024;
	localparam int unsigned WORD_W_DEF = 32;

	// opcodes
	localparam logic [2:0] OP_APPEND  = 3'd0;
	localparam logic [2:0] OP_LINEAR  = 3'd1;
	localparam logic [2:0] OP_ORDERED = 3'd2;
	localparam logic [2:0] OP_BINARY  = 3'd3;
	localparam logic [2:0] OP_INSERT  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
		logic [10:0]        position;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  match_index;
		logic [1:0]  status;
		logic [10:0] entry_count_out;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_item;
		logic       do_append;
		logic       set_status;
		logic [1:0] status_code;
		logic       scan_init;
		logic       scan_issue;
		logic       set_found;
		logic       bin_init;
		logic       bin_issue;
		logic       bin_lt;
		logic       bin_gt;
		logic       shift_init;
		logic       shift_issue;
		logic       shift_wr;
		logic       put;
		logic       out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       pos_bad;
		logic       scan_more;
		logic       rd_valid;
		logic       hit;
		logic       key_lt;
		logic       bin_empty;
		logic       shift_more;
		logic       out_free;
	} sts_t;

endpackage

/* rtl/stsi_dpath.sv */
// ----------------------------------------------------------------------------
// stsi_dpath
// Table memory, entry count, scan and bisection pointers, result and
// output registers.
// ----------------------------------------------------------------------------
module stsi_dpath #(
	parameter int unsigned TABLE_DEPTH = stsi_pkg::DEPTH_DEF,
	parameter int unsigned WORD_WIDTH  = stsi_pkg::WORD_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stsi_pkg::req_t   req,
	input  stsi_pkg::cmd_t   cmd,
	output stsi_pkg::sts_t   sts,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output stsi_pkg::rsp_t   rsp
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned XW = (CW > 11) ? CW : 11;

	logic signed [WORD_WIDTH-1:0] mem [TABLE_DEPTH];

	logic [CW-1:0]                count_q;
	logic                         rd_valid_s1;
	logic                         out_valid_q;
	stsi_pkg::rsp_t               out_q;

	logic [2:0]                   op_q;
	logic signed [WORD_WIDTH-1:0] key_q;
	logic [10:0]                  pos_q;
	logic [CW-1:0]                ptr_q;
	logic [CW-1:0]                sp_q;
	logic signed [CW:0]           lo_q;
	logic signed [CW:0]           hi_q;
	logic signed [WORD_WIDTH-1:0] rd_data_s1;
	logic [IW-1:0]                addr_s1;
	logic                         found_q;
	logic [IW-1:0]                idx_q;
	logic [1:0]                   status_q;

	logic [CW-1:0]                sp_m1;
	logic signed [CW+1:0]         mid_sum;
	logic [IW-1:0]                rd_addr;
	logic                         rd_en;
	logic [IW-1:0]                wr_addr;
	logic signed [WORD_WIDTH-1:0] wr_data;
	logic                         wr_en;
	logic signed [CW:0]           addr_x;

	assign sp_m1   = sp_q - 1'b1;
	assign mid_sum = (CW+2)'(lo_q) + (CW+2)'(hi_q);
	assign addr_x  = $signed({1'b0, CW'(addr_s1)});

	// read port select
	always_comb begin
		rd_en   = cmd.scan_issue | cmd.bin_issue | cmd.shift_issue;
		rd_addr = ptr_q[IW-1:0];
		if (cmd.bin_issue) begin
			rd_addr = IW'(mid_sum >>> 1);
		end else if (cmd.shift_issue) begin
			rd_addr = sp_m1[IW-1:0];
		end
	end

	// write port select
	always_comb begin
		wr_en   = cmd.do_append | cmd.shift_wr | cmd.put;
		wr_addr = count_q[IW-1:0];
		wr_data = key_q;
		if (cmd.shift_wr) begin
			wr_addr = addr_s1 + 1'b1;
			wr_data = rd_data_s1;
		end else if (cmd.put) begin
			wr_addr = IW'(pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_issue | cmd.shift_issue;
			if (cmd.do_append || cmd.put) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= req.opcode;
			key_q    <= WORD_WIDTH'(req.value);
			pos_q    <= req.position;
			found_q  <= 1'b0;
			idx_q    <= '0;
			status_q <= stsi_pkg::ST_OK;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.set_found) begin
			found_q <= 1'b1;
			idx_q   <= addr_s1;
		end
		if (cmd.scan_init) begin
			ptr_q <= '0;
		end else if (cmd.scan_issue) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.shift_init) begin
			sp_q <= count_q;
		end else if (cmd.shift_issue) begin
			sp_q <= sp_m1;
		end
		if (cmd.bin_init) begin
			lo_q <= '0;
			hi_q <= $signed({1'b0, count_q}) - 2'sd1;
		end else if (cmd.bin_lt) begin
			hi_q <= addr_x - 2'sd1;
		end else if (cmd.bin_gt) begin
			lo_q <= addr_x + 2'sd1;
		end
		if (cmd.out_load) begin
			out_q.found           <= found_q;
			out_q.match_index     <= 10'(idx_q);
			out_q.status          <= status_q;
			out_q.entry_count_out <= 11'(count_q);
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.full       = (count_q == CW'(TABLE_DEPTH));
		sts.pos_bad    = (XW'(pos_q) > XW'(count_q));
		sts.scan_more  = (ptr_q < count_q);
		sts.rd_valid   = rd_valid_s1;
		sts.hit        = (rd_data_s1 == key_q);
		sts.key_lt     = (key_q < rd_data_s1);
		sts.bin_empty  = (lo_q > hi_q);
		sts.shift_more = (XW'(sp_q) > XW'(pos_q));
		sts.out_free   = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

/* rtl/stsi_ctrl.sv */
// ----------------------------------------------------------------------------
// stsi_ctrl
// Sequencer: decodes an accepted item and steps the datapath through the
// append, scan, bisection or shift-and-insert sequence.
// ----------------------------------------------------------------------------
module stsi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  stsi_pkg::sts_t sts,
	output stsi_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_BIN_RD,
		S_BIN_CMP,
		S_SHIFT,
		S_PUT,
		S_FIN
	} state_t;

	state_t state_q;
	logic   ordered;

	assign req_stall = (state_q != S_IDLE);
	assign ordered   = (sts.op == stsi_pkg::OP_ORDERED);

	always_comb begin
		cmd             = '0;
		cmd.status_code = stsi_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = req_valid;
			end
			S_EXEC: begin
				case (sts.op)
					stsi_pkg::OP_APPEND: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = stsi_pkg::ST_FULL;
						end else begin
							cmd.do_append = 1'b1;
						end
					end
					stsi_pkg::OP_LINEAR, stsi_pkg::OP_ORDERED: begin
						cmd.scan_init = 1'b1;
					end
					stsi_pkg::OP_BINARY: begin
						cmd.bin_init = 1'b1;
					end
					stsi_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = stsi_pkg::ST_FULL;
						end else if (sts.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = stsi_pkg::ST_BADPOS;
						end else begin
							cmd.shift_init = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SRCH: begin
				cmd.scan_issue = sts.scan_more;
				cmd.set_found  = sts.rd_valid && sts.hit;
			end
			S_BIN_RD: begin
				cmd.bin_issue = !sts.bin_empty;
			end
			S_BIN_CMP: begin
				cmd.set_found = sts.hit;
				cmd.bin_lt    = !sts.hit && sts.key_lt;
				cmd.bin_gt    = !sts.hit && !sts.key_lt;
			end
			S_SHIFT: begin
				cmd.shift_issue = sts.shift_more;
				cmd.shift_wr    = sts.rd_valid;
			end
			S_PUT: begin
				cmd.put = 1'b1;
			end
			S_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (sts.op)
						stsi_pkg::OP_LINEAR, stsi_pkg::OP_ORDERED: state_q <= S_SRCH;
						stsi_pkg::OP_BINARY: state_q <= S_BIN_RD;
						stsi_pkg::OP_INSERT: begin
							if (sts.full || sts.pos_bad) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_SHIFT;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_SRCH: begin
					if (sts.rd_valid) begin
						if (sts.hit || (ordered && sts.key_lt)) begin
							state_q <= S_FIN;
						end
					end else if (!sts.scan_more) begin
						state_q <= S_FIN;
					end
				end
				S_BIN_RD: begin
					if (sts.bin_empty) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_BIN_CMP;
					end
				end
				S_BIN_CMP: begin
					if (sts.hit) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_BIN_RD;
					end
				end
				S_SHIFT: begin
					if (!sts.shift_more && !sts.rd_valid) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/sorted_table_search_insert.sv */
// ----------------------------------------------------------------------------
// sorted_table_search_insert
// Table of signed words with append, linear/ordered/binary search and
// insert-with-shift; one result per request.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_stall  | opcode, value, position
//  rsp     | out       | rsp_valid/rsp_stall  | found, match_index, status,
//          |           |                      | entry_count_out
//
//  One request at a time. The table lives in a single-port-read,
//  single-port-write memory with registered read data, and each access
//  to the table goes through that memory port. Linear/ordered search
//  reads the entries one by one, binary search one midpoint per probe,
//  and insert moves each entry at or above the position up by one
//  before it writes the value at the position.
//  Reset clears the entry count and all control; table words are not
//  cleared (only entries below the count are ever read).
//  The result sits in an output register, so a stalled rsp holds only the
//  finish of the following request, never its transfer on req.
//
module sorted_table_search_insert #(
	parameter int unsigned TABLE_DEPTH = stsi_pkg::DEPTH_DEF,
	parameter int unsigned WORD_WIDTH  = stsi_pkg::WORD_W_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  stsi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output stsi_pkg::rsp_t rsp
);

	// command and status between the sequencer and the datapath
	stsi_pkg::cmd_t cmd;
	stsi_pkg::sts_t sts;

	// sequencer: decode, walk and hand off the result
	stsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: table memory, count, pointers, output register
	stsi_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WORD_WIDTH  (WORD_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
